// ===== src/distance_spawn_emitter_assert.svh =====
// Assertion macros shared by the checker files of the spawn emitter.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef DISTANCE_SPAWN_EMITTER_ASSERT_SVH
`define DISTANCE_SPAWN_EMITTER_ASSERT_SVH

// Same-cycle implication.
`define DSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DSE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/dse_pkg.sv =====
// Shared types and constants of the distance spawn emitter.
// Used by the controller, the datapath and the top level.
package dse_pkg;

  localparam int unsigned PosW      = 24;
  localparam int unsigned SlotW     = 16;
  localparam int unsigned CountW    = 7;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = 24;
  localparam int unsigned CntW      = 6;
  localparam int unsigned SqrtSteps = 25;
  localparam int unsigned IncSteps  = 49;
  localparam int unsigned AxSteps   = 26;

  localparam logic [CfgAddrW-1:0] RegUnitScalar = 3'd0;
  localparam logic [CfgAddrW-1:0] RegSpawnPerUnit = 3'd1;
  localparam logic [CfgAddrW-1:0] RegMoveTol = 3'd2;
  localparam logic [CfgAddrW-1:0] RegMaxDist = 3'd3;
  localparam logic [CfgAddrW-1:0] RegIgnoreZ = 3'd4;
  localparam logic [CfgAddrW-1:0] RegLocalSpace = 3'd5;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_FIRST,
    OP_SQ,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_CLR_FRAC,
    OP_MUL,
    OP_DIV_INC_LOAD,
    OP_DIV_STEP,
    OP_COMMIT,
    OP_AX_LOAD,
    OP_AX_STORE,
    OP_EMIT_INIT,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic disabled;
    logic seen;
    logic tol_hit;
    logic too_far;
    logic n_zero;
    logic emit_last;
  } status_t;

endpackage

// ===== src/dse_ctrl.sv =====
// Sequencer of the distance spawn emitter: state machine, step counter,
// output valid. Depends on dse_pkg.
module dse_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  input  dse_pkg::status_t status_i,
  output dse_pkg::cmd_t    cmd_o
);
  import dse_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_SQ, S_SQRTI, S_SQRT, S_CHECK, S_DIVL, S_DIVI,
    S_COMMIT, S_NCHK, S_AXL, S_AXD, S_AXS, S_EMITI, S_EMIT
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [1:0]      axis_q, axis_d;
  logic            ovalid_q, ovalid_d;
  logic            emit_go;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;
  assign emit_go     = (state_q == S_EMIT) && (!ovalid_q || out_ready_i);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    axis_d     = axis_q;
    cmd_o.op   = OP_NONE;
    cmd_o.axis = axis_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_START;
        end
      end
      S_START: begin
        if (status_i.disabled) begin
          state_d = S_IDLE;
        end else if (!status_i.seen) begin
          cmd_o.op = OP_FIRST;
          state_d  = S_IDLE;
        end else begin
          axis_d  = 2'd0;
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        cmd_o.op = OP_SQ;
        if (axis_q == 2'd2) state_d = S_SQRTI;
        else axis_d = axis_q + 2'd1;
      end
      S_SQRTI: begin
        cmd_o.op = OP_SQRT_INIT;
        cnt_d    = CntW'(SqrtSteps - 1);
        state_d  = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.op = OP_SQRT_STEP;
        if (cnt_q == '0) state_d = S_CHECK;
        else cnt_d = cnt_q - 1'b1;
      end
      S_CHECK: begin
        if (status_i.tol_hit) begin
          state_d = S_IDLE;
        end else if (status_i.too_far) begin
          cmd_o.op = OP_CLR_FRAC;
          state_d  = S_IDLE;
        end else begin
          cmd_o.op = OP_MUL;
          state_d  = S_DIVL;
        end
      end
      S_DIVL: begin
        cmd_o.op = OP_DIV_INC_LOAD;
        cnt_d    = CntW'(IncSteps - 1);
        state_d  = S_DIVI;
      end
      S_DIVI: begin
        cmd_o.op = OP_DIV_STEP;
        if (cnt_q == '0) state_d = S_COMMIT;
        else cnt_d = cnt_q - 1'b1;
      end
      S_COMMIT: begin
        cmd_o.op = OP_COMMIT;
        state_d  = S_NCHK;
      end
      S_NCHK: begin
        axis_d  = 2'd0;
        state_d = status_i.n_zero ? S_IDLE : S_AXL;
      end
      S_AXL: begin
        cmd_o.op = OP_AX_LOAD;
        cnt_d    = CntW'(AxSteps - 1);
        state_d  = S_AXD;
      end
      S_AXD: begin
        cmd_o.op = OP_DIV_STEP;
        if (cnt_q == '0) state_d = S_AXS;
        else cnt_d = cnt_q - 1'b1;
      end
      S_AXS: begin
        cmd_o.op = OP_AX_STORE;
        if (axis_q == 2'd2) state_d = S_EMITI;
        else begin
          axis_d  = axis_q + 2'd1;
          state_d = S_AXL;
        end
      end
      S_EMITI: begin
        cmd_o.op = OP_EMIT_INIT;
        state_d  = S_EMIT;
      end
      S_EMIT: begin
        if (emit_go) begin
          cmd_o.op = OP_EMIT;
          if (status_i.emit_last) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (emit_go) ovalid_d = 1'b1;
    else if (out_ready_i) ovalid_d = 1'b0;
    else ovalid_d = ovalid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      axis_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      axis_q   <= axis_d;
      ovalid_q <= ovalid_d;
    end
  end

endmodule

// ===== src/dse_datapath.sv =====
// Datapath of the distance spawn emitter: config registers, frame state,
// shared multiplier, bit-serial root, restoring divider, point stepper.
// Depends on dse_pkg.
module dse_datapath #(
  parameter int unsigned MAX_BURST = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [dse_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [dse_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic [dse_pkg::PosW-1:0]     in_x_i,
  input  logic [dse_pkg::PosW-1:0]     in_y_i,
  input  logic [dse_pkg::PosW-1:0]     in_z_i,
  input  logic [dse_pkg::SlotW-1:0]    in_slots_i,
  input  dse_pkg::cmd_t                cmd_i,
  output dse_pkg::status_t             status_o,
  output logic [dse_pkg::PosW-1:0]     out_x_o,
  output logic [dse_pkg::PosW-1:0]     out_y_o,
  output logic [dse_pkg::PosW-1:0]     out_z_o,
  output logic                         out_last_o
);
  import dse_pkg::*;

  localparam logic [CountW-1:0] MaxBurst = CountW'(MAX_BURST);

  // configuration
  logic [23:0] unit_q, tol_q, maxd_q;
  logic [15:0] spu_q;
  logic        ignz_q, local_q;

  // frame state
  logic [PosW-1:0]  prev_q [3];
  logic [PosW-1:0]  base_q [3];
  logic [PosW-1:0]  cur_q  [3];
  logic [PosW:0]    trav_q [3];
  logic [15:0]      frac_q;
  logic             seen_q;
  logic [SlotW-1:0] slots_q;

  // arithmetic
  logic signed [25:0] mul_a, mul_b;
  logic signed [51:0] prod_q;
  logic [49:0] sq_q, rad_q;
  logic [26:0] rem_q;
  logic [24:0] root_q;
  logic [48:0] dvd_q;
  logic [23:0] drem_q, dvs_q;
  logic [CountW-1:0] n_q, left_q;
  logic [24:0] q0_q [3];
  logic [7:0]  r0_q [3];
  logic [24:0] qa_q [3];
  logic [8:0]  ra_q [3];
  logic [PosW-1:0] ox_q, oy_q, oz_q;
  logic            olast_q;

  // combinational helpers
  logic [PosW:0]   t_raw;
  logic [PosW:0]   t_sel;
  logic [PosW:0]   mag;
  logic [28:0]     rem2;
  logic [26:0]     trial;
  logic [24:0]     dsh;
  logic            dge;
  logic [49:0]     total;
  logic [33:0]     count;
  logic [SlotW-1:0] cap1;
  logic [CountW-1:0] ncap;
  logic [7:0]      two_d;
  logic [PosW:0]   new_t [3];
  logic [8:0]      rs [3];
  logic [24:0]     qs [3];
  logic            wrap [3];
  logic [8:0]      rn [3];
  logic [24:0]     qn [3];
  logic [PosW-1:0] pt [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      new_t[a] = {cur_q[a][PosW-1], cur_q[a]} - {prev_q[a][PosW-1], prev_q[a]};
    end
  end

  // the X square is taken while the travel registers are still loading
  assign t_raw = (cmd_i.op == OP_SQ && cmd_i.axis == 2'd0) ? new_t[0]
                                                           : trav_q[cmd_i.axis];
  assign t_sel = (cmd_i.axis == 2'd2 && ignz_q) ? '0 : t_raw;
  assign mag   = trav_q[cmd_i.axis][PosW] ? (~trav_q[cmd_i.axis] + 1'b1)
                                          : trav_q[cmd_i.axis];

  always_comb begin
    if (cmd_i.op == OP_MUL) begin
      mul_a = signed'({1'b0, root_q});
      mul_b = signed'({10'd0, spu_q});
    end else begin
      mul_a = signed'({t_sel[PosW], t_sel});
      mul_b = signed'({t_sel[PosW], t_sel});
    end
  end

  assign rem2  = {rem_q, rad_q[49:48]};
  assign trial = {root_q, 2'b01};
  assign dsh   = {drem_q, dvd_q[48]};
  assign dge   = (dsh >= {1'b0, dvs_q});
  assign total = {1'b0, dvd_q} + {34'd0, frac_q};
  assign count = total[49:16];
  assign cap1  = (count > {18'd0, slots_q}) ? slots_q : count[15:0];
  assign ncap  = (cap1 > {9'd0, MaxBurst}) ? MaxBurst : cap1[CountW-1:0];
  assign two_d = {n_q, 1'b0} + 8'd2;

  // advance each axis: add 2|t| = q0*2d + r0, carry once when the remainder wraps
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      rs[a]   = ra_q[a] + {1'b0, r0_q[a]};
      qs[a]   = qa_q[a] + q0_q[a];
      wrap[a] = (rs[a] >= {1'b0, two_d});
      rn[a]   = wrap[a] ? rs[a] - {1'b0, two_d} : rs[a];
      qn[a]   = wrap[a] ? qs[a] + 25'd1 : qs[a];
      pt[a]   = local_q ? '0 :
                (trav_q[a][PosW] ? base_q[a] - qn[a][PosW-1:0]
                                 : base_q[a] + qn[a][PosW-1:0]);
    end
  end

  assign status_o.disabled  = (unit_q == '0) || (spu_q == '0);
  assign status_o.seen      = seen_q;
  assign status_o.tol_hit   = (root_q <= {1'b0, tol_q});
  assign status_o.too_far   = (maxd_q != '0) && (root_q > {1'b0, maxd_q});
  assign status_o.n_zero    = (n_q == '0);
  assign status_o.emit_last = (left_q == CountW'(1));

  assign out_x_o    = ox_q;
  assign out_y_o    = oy_q;
  assign out_z_o    = oz_q;
  assign out_last_o = olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_q  <= 24'd256;
      spu_q   <= 16'd256;
      tol_q   <= '0;
      maxd_q  <= '0;
      ignz_q  <= 1'b0;
      local_q <= 1'b0;
      prev_q  <= '{default: '0};
      frac_q  <= '0;
      seen_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          RegUnitScalar:   unit_q  <= cfg_wdata_i;
          RegSpawnPerUnit: spu_q   <= cfg_wdata_i[15:0];
          RegMoveTol:      tol_q   <= cfg_wdata_i;
          RegMaxDist:      maxd_q  <= cfg_wdata_i;
          RegIgnoreZ:      ignz_q  <= cfg_wdata_i[0];
          RegLocalSpace:   local_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      case (cmd_i.op)
        OP_FIRST: begin
          prev_q <= cur_q;
          frac_q <= '0;
          seen_q <= 1'b1;
        end
        OP_SQ: begin
          if (cmd_i.axis == 2'd0) prev_q <= cur_q;
        end
        OP_CLR_FRAC: frac_q <= '0;
        OP_COMMIT:   frac_q <= total[15:0];
        default: ;
      endcase
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        cur_q[0] <= in_x_i;
        cur_q[1] <= in_y_i;
        cur_q[2] <= in_z_i;
        slots_q  <= in_slots_i;
      end
      OP_SQ: begin
        prod_q <= mul_a * mul_b;
        if (cmd_i.axis == 2'd0) begin
          sq_q   <= '0;
          base_q <= prev_q;
          trav_q <= new_t;
        end else begin
          sq_q <= sq_q + prod_q[49:0];
        end
      end
      OP_SQRT_INIT: begin
        rad_q  <= sq_q + prod_q[49:0];
        rem_q  <= '0;
        root_q <= '0;
      end
      OP_SQRT_STEP: begin
        rad_q <= {rad_q[47:0], 2'b00};
        if (rem2 >= {2'b00, trial}) begin
          rem_q  <= 27'(rem2 - {2'b00, trial});
          root_q <= {root_q[23:0], 1'b1};
        end else begin
          rem_q  <= rem2[26:0];
          root_q <= {root_q[23:0], 1'b0};
        end
      end
      OP_MUL: prod_q <= mul_a * mul_b;
      OP_DIV_INC_LOAD: begin
        dvd_q  <= {prod_q[40:0], 8'd0};
        drem_q <= '0;
        dvs_q  <= unit_q;
      end
      OP_DIV_STEP: begin
        drem_q <= dge ? 24'(dsh - {1'b0, dvs_q}) : dsh[23:0];
        dvd_q  <= {dvd_q[47:0], dge};
      end
      OP_COMMIT: n_q <= ncap;
      OP_AX_LOAD: begin
        dvd_q  <= {mag, 1'b0, 23'd0};
        drem_q <= '0;
        dvs_q  <= {16'd0, two_d};
      end
      OP_AX_STORE: begin
        q0_q[cmd_i.axis] <= dvd_q[24:0];
        r0_q[cmd_i.axis] <= drem_q[7:0];
      end
      OP_EMIT_INIT: begin
        qa_q   <= '{default: '0};
        ra_q   <= '{default: {2'b00, n_q} + 9'd1};
        left_q <= n_q;
      end
      OP_EMIT: begin
        qa_q    <= qn;
        ra_q    <= rn;
        left_q  <= left_q - 1'b1;
        ox_q    <= pt[0];
        oy_q    <= pt[1];
        oz_q    <= pt[2];
        olast_q <= (left_q == CountW'(1));
      end
      default: ;
    endcase
  end

endmodule

// ===== src/distance_spawn_emitter.sv =====
// Top level of the distance spawn emitter: stream ports, config port,
// controller and datapath. Depends on dse_pkg, dse_ctrl, dse_datapath.
//
// One input word per frame carries the emitter position and the free slot
// count. The first enabled frame only records the position. Later frames
// measure the travel from the previous position (Z dropped when
// ignore_z_travel is set), take floor(sqrt) of the squared length, and if it
// lies above the tolerance and within the jump limit add
// dist*spawn_per_unit*256/unit_scalar to a 16-bit fractional remainder. The
// integer part, capped by free_slots and MAX_BURST, gives the number of
// output words; they lie at (i+1)/(n+1) of the raw travel, rounded half away
// from zero, or at the origin in local-space mode, and tlast marks the last
// one. A disabled or first frame goes straight back to idle from the start
// state. A frame that moves is squared per axis and runs through the
// bit-serial square root to the tolerance check, then through one 49-step
// pass of the shared restoring divider for the increment and spawn count,
// then divides each axis by 2(n+1) in that same divider, sets up the point
// stepper, and gives one spawn point per cycle while the output is taken.
// The input accepts a word only when the previous frame is done; a finished
// output word waits in the output register without blocking that.
module distance_spawn_emitter #(
  parameter int unsigned MAX_BURST = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic                         cfg_we_i,
  input  logic [dse_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [dse_pkg::CfgDataW-1:0] cfg_wdata_i,
  // frame input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,  // pos_x, pos_y, pos_z, free_slots
  // spawn points
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // spawn_x, spawn_y, spawn_z
  output logic        m_axis_tlast   // last_spawn
);
  import dse_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic [PosW-1:0] sx, sy, sz;

  dse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  dse_datapath #(
    .MAX_BURST (MAX_BURST)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_x_i      (s_axis_tdata[23:0]),
    .in_y_i      (s_axis_tdata[47:24]),
    .in_z_i      (s_axis_tdata[71:48]),
    .in_slots_i  (s_axis_tdata[87:72]),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_x_o     (sx),
    .out_y_o     (sy),
    .out_z_o     (sz),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {sz, sy, sx};

endmodule

// ===== src/dse_checker.sv =====
// Port-level checks of the distance spawn emitter and their bind.
// Depends on distance_spawn_emitter_assert.svh.
`include "distance_spawn_emitter_assert.svh"

module dse_port_props (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // a stalled word holds
  `DSE_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled spawn word changed")

  // only the last word of a frame may still wait once the input is open
  `DSE_ASSERT_IMP(a_idle_last, s_axis_tready && m_axis_tvalid, m_axis_tlast, "non-last word pending while idle")

  // one frame at a time
  `DSE_ASSERT_NXT(a_busy_after_in, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input open right after accept")

endmodule

bind distance_spawn_emitter dse_port_props u_dse_port_props (.*);
